### hw/rtl/swfc_pkg.sv
// Shared types and constants for the sliding window frame cache tag engine.
// Used by swfc_cell and sliding_window_frame_cache_top; depends on nothing.
`default_nettype none

package swfc_pkg;

   localparam int FRAME_W    = 24;
   localparam int CENTER_W   = 25;
   localparam int CYCLE_W    = 8;
   localparam int TAG_W      = 26;
   localparam int DIST_W     = TAG_W + 1;
   localparam int REQ_DATA_W = ((CENTER_W + FRAME_W + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = FRAME_W;

   typedef logic signed [TAG_W-1:0] tag_type;

   localparam tag_type EMPTY_TAG = tag_type'(-20);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_FRAMES  = 2'd2;

   // Flags of the token that walks the cell chain.
   typedef struct packed {
      logic go;
      logic found;
      logic hit;
      logic fetched;
   } swfc_tok_type;

   // Broadcast controls from the sequencer to every cell.
   typedef struct packed {
      logic retag;
      logic clear;
   } swfc_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/swfc_cell.sv
// One slot of the tag ring: holds the slot tag and valid bit and processes the
// token passed from its left neighbor. Depends on swfc_pkg.
`default_nettype none

module swfc_cell #(
   parameter int DEPTH = 16,
   parameter int IDX   = 0,
   localparam int SLOT_W = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire swfc_pkg::swfc_ctl_type ctl,
   input  wire swfc_pkg::tag_type     first,
   input  wire swfc_pkg::tag_type     want,
   input  wire logic [SLOT_W-1:0]     origin,
   input  wire swfc_pkg::swfc_tok_type tok_prev,
   input  wire swfc_pkg::tag_type     f_prev,
   input  wire logic [SLOT_W-1:0]     idx_prev,
   output swfc_pkg::swfc_tok_type     tok_out,
   output swfc_pkg::tag_type          f_out,
   output logic [SLOT_W-1:0]          idx_out
);
   import swfc_pkg::*;

   localparam int OW = SLOT_W + 2;

   tag_type               tag_ff, tag_in;
   logic                  valid_ff, valid_in;
   swfc_tok_type          tok_ff, tok_in;
   tag_type               f_ff, f_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;

   tag_type               f_here;
   logic signed [DIST_W-1:0] tag_gap;
   logic                  in_win;
   logic signed [OW-1:0]  org_raw, org_fix;

   always_comb begin
      // The ring position counter restarts at the window start on the origin slot.
      f_here  = (SLOT_W'(IDX) == origin) ? first : f_prev;
      tag_gap = DIST_W'(tag_ff) - DIST_W'(first);
      in_win  = !tag_gap[DIST_W-1] && (tag_gap <= DIST_W'(DEPTH));
      org_raw = OW'(IDX) - OW'(tag_gap);
      org_fix = org_raw[OW-1] ? org_raw + OW'(DEPTH) : org_raw;

      tok_in   = tok_prev;
      f_in     = f_here + tag_type'(1);
      idx_in   = idx_prev;
      tag_in   = tag_ff;
      valid_in = valid_ff;

      if (ctl.clear) begin
         tag_in   = EMPTY_TAG;
         valid_in = 1'b0;
      end else if (tok_prev.go) begin
         if (!ctl.retag) begin
            // All valid tags follow the old origin, so any match in the window
            // yields the same new origin.
            if (!tok_prev.found && valid_ff && in_win) begin
               tok_in.found = 1'b1;
               idx_in       = org_fix[SLOT_W-1:0];
            end
         end else begin
            if (f_here == want) begin
               if (valid_ff && (tag_ff == f_here)) begin
                  tok_in.hit = 1'b1;
               end else begin
                  tag_in         = f_here;
                  valid_in       = 1'b1;
                  tok_in.fetched = 1'b1;
               end
               idx_in = SLOT_W'(IDX);
            end else if (tag_ff != f_here) begin
               tag_in   = f_here;
               valid_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         tag_ff   <= EMPTY_TAG;
         valid_ff <= 1'b0;
      end else begin
         tok_ff   <= tok_in;
         tag_ff   <= tag_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff   <= f_in;
      idx_ff <= idx_in;
   end

   assign tok_out = tok_ff;
   assign f_out   = f_ff;
   assign idx_out = idx_ff;

endmodule

`default_nettype wire

### hw/rtl/sliding_window_frame_cache_top.sv
// Sliding window frame cache tag engine, top level (uses swfc_pkg and swfc_cell).
// A ring of DEPTH cells holds slot tags and valid bits. One request transaction
// is processed at a time: a check cycle for the center frame, then a token walks
// the cell chain twice, once to find the new ring origin (the ring is cleared if
// no valid slot lies in the window) and once to re-tag every slot. A bad center
// goes straight from the check to the response. The response is held in an output
// register, and req_tready is high only while the engine is idle. Configuration
// writes must be issued only while no request is in flight.
`default_nettype none

module sliding_window_frame_cache_top #(
   parameter int DEPTH = 16,
   localparam int SLOT_W     = $clog2(DEPTH),
   localparam int RSP_DATA_W = ((swfc_pkg::FRAME_W + SLOT_W + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request: [24:0] center_frame (signed), [48:25] req_frame
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [swfc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Response data: [23:0] fetch_index, then slot_index
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [RSP_DATA_W-1:0]                  rsp_tdata,
   // Response user: [0] bad_center, [1] hit, [2] need_fetch, [3] stored
   output logic [3:0]                             rsp_tuser,
   input  wire logic                              csr_wen,
   input  wire logic [swfc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [swfc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import swfc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_RETAG,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic stored;
      logic need_fetch;
      logic hit;
      logic bad_center;
   } rsp_flags_type;

   state_type                   state_ff;
   logic                        mode_ff;
   logic [CYCLE_W-1:0]          cycle_ff;
   logic [FRAME_W-1:0]          clip_ff;
   logic signed [CENTER_W-1:0]  center_ff;
   logic [FRAME_W-1:0]          want_ff;
   tag_type                     first_ff;
   logic [SLOT_W-1:0]           origin_ff;
   logic                        head_go_ff;
   rsp_flags_type               res_flags_ff;
   logic [FRAME_W-1:0]          res_fetch_ff;
   logic [SLOT_W-1:0]           res_slot_ff;
   logic                        rsp_tvalid_ff;
   rsp_flags_type               rsp_flags_ff;
   logic [FRAME_W-1:0]          rsp_fetch_ff;
   logic [SLOT_W-1:0]           rsp_slot_ff;

   swfc_ctl_type                ctl;
   swfc_tok_type                tok_chain [DEPTH+1];
   tag_type                     f_chain   [DEPTH+1];
   logic [SLOT_W-1:0]           idx_chain [DEPTH+1];
   tag_type                     want_tag;
   tag_type                     center_tag;
   logic                        bad;
   swfc_tok_type                tail;

   assign want_tag   = tag_type'(want_ff);
   assign center_tag = tag_type'(center_ff);
   assign bad        = center_ff[CENTER_W-1] || (center_ff[FRAME_W-1:0] >= clip_ff);
   assign tail       = tok_chain[DEPTH];

   assign ctl.retag = (state_ff == ST_RETAG);
   assign ctl.clear = (state_ff == ST_SCAN) && tail.go && !tail.found;

   assign tok_chain[0] = '{go: head_go_ff, found: 1'b0, hit: 1'b0, fetched: 1'b0};
   // Cell 0 sits DEPTH - origin positions past the window start.
   assign f_chain[0]   = first_ff + tag_type'(DEPTH) - tag_type'(origin_ff);
   assign idx_chain[0] = '0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      swfc_cell #(
         .DEPTH (DEPTH),
         .IDX   (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .first    (first_ff),
         .want     (want_tag),
         .origin   (origin_ff),
         .tok_prev (tok_chain[k]),
         .f_prev   (f_chain[k]),
         .idx_prev (idx_chain[k]),
         .tok_out  (tok_chain[k+1]),
         .f_out    (f_chain[k+1]),
         .idx_out  (idx_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         cycle_ff <= CYCLE_W'(5);
         clip_ff  <= FRAME_W'(1);
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_WINDOW_MODE:  mode_ff  <= csr_wdata[0];
            CSR_CYCLE_LENGTH: cycle_ff <= csr_wdata[CYCLE_W-1:0];
            CSR_CLIP_FRAMES:  clip_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         origin_ff     <= '0;
         head_go_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // A token is launched after a good center check and after the origin walk.
         head_go_ff    <= ((state_ff == ST_CHECK) && !bad) ||
                          ((state_ff == ST_SCAN) && tail.go);
         rsp_tvalid_ff <= (state_ff == ST_DONE) || (rsp_tvalid_ff && !rsp_tready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  center_ff <= req_tdata[CENTER_W-1:0];
                  want_ff   <= req_tdata[CENTER_W+FRAME_W-1:CENTER_W];
                  state_ff  <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (bad) begin
                  res_flags_ff <= '{stored: 1'b0, need_fetch: 1'b0, hit: 1'b0,
                                    bad_center: 1'b1};
                  res_fetch_ff <= '0;
                  res_slot_ff  <= '0;
                  state_ff     <= ST_DONE;
               end else begin
                  first_ff <= mode_ff
                     ? center_tag - tag_type'(cycle_ff) - tag_type'(1)
                     : center_tag - tag_type'(DEPTH / 2);
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (tail.go) begin
                  origin_ff <= tail.found ? idx_chain[DEPTH] : '0;
                  state_ff  <= ST_RETAG;
               end
            end
            ST_RETAG: begin
               if (tail.go) begin
                  if (tail.fetched) begin
                     res_flags_ff <= '{stored: 1'b1, need_fetch: 1'b1, hit: 1'b0,
                                       bad_center: 1'b0};
                     res_fetch_ff <= (want_ff >= clip_ff) ? clip_ff - FRAME_W'(1) : want_ff;
                     res_slot_ff  <= idx_chain[DEPTH];
                  end else if (tail.hit) begin
                     res_flags_ff <= '{stored: 1'b0, need_fetch: 1'b0, hit: 1'b1,
                                       bad_center: 1'b0};
                     res_fetch_ff <= '0;
                     res_slot_ff  <= idx_chain[DEPTH];
                  end else begin
                     res_flags_ff <= '{stored: 1'b0, need_fetch: 1'b1, hit: 1'b0,
                                       bad_center: 1'b0};
                     res_fetch_ff <= want_ff;
                     res_slot_ff  <= '0;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_flags_ff <= res_flags_ff;
                  rsp_fetch_ff <= res_fetch_ff;
                  rsp_slot_ff  <= res_slot_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_slot_ff, rsp_fetch_ff});
   assign rsp_tuser  = rsp_flags_ff;

   a_bad_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_flags_ff.bad_center |->
         !rsp_flags_ff.hit && !rsp_flags_ff.need_fetch && !rsp_flags_ff.stored)
      else $error("bad center response carries other flags");

   a_hit_or_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_flags_ff.hit && rsp_flags_ff.need_fetch))
      else $error("response is both a hit and a fetch");

   a_stored_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_flags_ff.stored |-> rsp_flags_ff.need_fetch)
      else $error("stored response without fetch");

   a_token_phase: assert property (@(posedge clock) disable iff (reset)
      tail.go |-> (state_ff == ST_SCAN) || (state_ff == ST_RETAG))
      else $error("token left the chain outside a walk");

   a_clear_origin: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> (origin_ff == '0) && (state_ff == ST_RETAG))
      else $error("ring clear did not reset the origin");

endmodule

`default_nettype wire

### dv/sliding_window_frame_cache_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the sliding window frame cache: follows register writes, predicts the
// response to every accepted request and compares it with each response transaction.
// Depends on swfc_pkg for widths, the slot tag type and the register indexes.

module sliding_window_frame_cache_checker #(
   parameter int DEPTH = 16,
   localparam int SLOT_W     = $clog2(DEPTH),
   localparam int RSP_DATA_W = ((swfc_pkg::FRAME_W + SLOT_W + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   // [24:0] center_frame (signed), [48:25] req_frame
   input  logic [swfc_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [23:0] fetch_index, then slot_index
   input  logic [RSP_DATA_W-1:0]                  rsp_tdata,
   // [0] bad_center, [1] hit, [2] need_fetch, [3] stored
   input  logic [3:0]                             rsp_tuser,
   input  logic                                   csr_wen,
   input  logic [swfc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [swfc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output int                                     fail_count,
   output int                                     pending
);
   import swfc_pkg::*;

   typedef struct packed {
      logic               bad_center;
      logic               hit;
      logic               need_fetch;
      logic [FRAME_W-1:0] fetch_index;
      logic               stored;
      logic [SLOT_W-1:0]  slot_index;
   } lookup_type;

   // Shadow copies of the registers and of the tag ring.
   logic               window_trails;
   logic [CYCLE_W-1:0] cycle_len;
   logic [FRAME_W-1:0] clip_len;
   tag_type            slot_tag_q [DEPTH];
   logic               slot_live  [DEPTH];
   logic [SLOT_W-1:0]  ring_base;

   lookup_type expected_lookups [$];
   lookup_type exp_rsp;
   int         mismatch_total = 0;
   int         outstanding_lookups = 0;

   assign fail_count = mismatch_total;
   assign pending    = outstanding_lookups;

   function automatic void clear_ring();
      for (int k = 0; k < DEPTH; k++) begin
         slot_tag_q[k] = EMPTY_TAG;
         slot_live[k]  = 1'b0;
      end
      ring_base = '0;
   endfunction

   // The lowest window frame that is still cached keeps its place relative to the window.
   function automatic void realign_ring(input int first);
      int o;
      for (int d = 0; d <= DEPTH; d++) begin
         for (int k = 0; k < DEPTH; k++) begin
            if (slot_live[k] && slot_tag_q[k] == first + d) begin
               o = k - d;
               if (o < 0) o += DEPTH;
               ring_base = o[SLOT_W-1:0];
               return;
            end
         end
      end
      clear_ring();
   endfunction

   function automatic lookup_type predict_lookup(input logic signed [CENTER_W-1:0] center_in,
                                                 input logic [FRAME_W-1:0] want_in);
      lookup_type res;
      int         center;
      int         want;
      int         first;
      int         pos;
      int         filled;
      res    = '0;
      center = int'(center_in);
      want   = int'(want_in);
      filled = -1;
      if (center < 0 || center >= int'(clip_len)) begin
         res.bad_center = 1'b1;
         return res;
      end
      first = window_trails ? center - 1 - int'(cycle_len) : center - DEPTH / 2;
      realign_ring(first);
      for (int i = 0; i < DEPTH; i++) begin
         pos = (int'(ring_base) + i) % DEPTH;
         if (first + i == want && !(slot_tag_q[pos] == want && slot_live[pos])) begin
            slot_tag_q[pos] = tag_type'(first + i);
            slot_live[pos]  = 1'b1;
            filled          = pos;
         end else if (slot_tag_q[pos] != first + i) begin
            slot_tag_q[pos] = tag_type'(first + i);
            slot_live[pos]  = 1'b0;
         end
      end
      if (filled >= 0) begin
         res.need_fetch  = 1'b1;
         res.stored      = 1'b1;
         res.fetch_index = (want >= int'(clip_len)) ? clip_len - 1'b1 : want_in;
         res.slot_index  = filled[SLOT_W-1:0];
         return res;
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (slot_live[i] && slot_tag_q[i] == want) begin
            res.hit        = 1'b1;
            res.slot_index = i[SLOT_W-1:0];
            return res;
         end
      end
      // Outside the window: fetched for this request only, index left unclamped.
      res.need_fetch  = 1'b1;
      res.fetch_index = want_in;
      return res;
   endfunction

   function automatic void check_field(input string field, input int unsigned exp_val,
                                       input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", field, exp_val, act_val);
         mismatch_total++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         window_trails = 1'b0;
         cycle_len     = 8'd5;
         clip_len      = 24'd1;
         clear_ring();
         expected_lookups.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_WINDOW_MODE:  window_trails = csr_wdata[0];
               CSR_CYCLE_LENGTH: cycle_len     = csr_wdata[CYCLE_W-1:0];
               CSR_CLIP_FRAMES:  clip_len      = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_lookups.push_back(predict_lookup(req_tdata[CENTER_W-1:0],
                                                      req_tdata[CENTER_W +: FRAME_W]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lookups.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatch_total++;
            end else begin
               exp_rsp = expected_lookups.pop_front();
               check_field("bad_center", exp_rsp.bad_center, rsp_tuser[0]);
               check_field("hit", exp_rsp.hit, rsp_tuser[1]);
               check_field("need_fetch", exp_rsp.need_fetch, rsp_tuser[2]);
               check_field("stored", exp_rsp.stored, rsp_tuser[3]);
               check_field("fetch_index", exp_rsp.fetch_index, rsp_tdata[FRAME_W-1:0]);
               check_field("slot_index", exp_rsp.slot_index, rsp_tdata[FRAME_W +: SLOT_W]);
            end
         end
      end
      outstanding_lookups = expected_lookups.size();
   end

endmodule

### dv/sliding_window_frame_cache_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the sliding window frame cache: drives requests, register writes and
// response back-pressure, and gives the verdict. Uses swfc_pkg, the block and the checker.

module sliding_window_frame_cache_top_test;
   import swfc_pkg::*;

   localparam int DEPTH       = 16;
   localparam int SLOT_W      = $clog2(DEPTH);
   localparam int RSP_DATA_W  = ((FRAME_W + SLOT_W + 7) / 8) * 8;
   localparam int FRAME_MAX   = (1 << FRAME_W) - 1;
   localparam int PIPE_CYCLES = 2 * DEPTH + 5;
   localparam int RANDOM_REQS = 1400;
   // No register sits at this index; writes to it must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum {READY_ALWAYS, READY_COIN, READY_RARE} ready_style_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   wire                     req_tready;
   // [24:0] center_frame (signed), [48:25] req_frame
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   wire                     rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [23:0] fetch_index, then slot_index
   wire  [RSP_DATA_W-1:0]   rsp_tdata;
   // [0] bad_center, [1] hit, [2] need_fetch, [3] stored
   wire  [3:0]              rsp_tuser;
   logic                    csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   int fail_count;
   int pending;
   int burst_left = 0;
   int trails     = 0;
   int cycle_cfg  = 5;
   int clip_cfg   = 1;

   ready_style_type ready_style = READY_ALWAYS;
   int              style_left  = 0;

   sliding_window_frame_cache_top #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sliding_window_frame_cache_checker #(.DEPTH(DEPTH)) lookup_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver switches at random between styles of back-pressure.
   always @(negedge clock) begin
      if (style_left == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 2));
         style_left  = $urandom_range(20, 300);
      end
      style_left--;
      case (ready_style)
         READY_ALWAYS: rsp_tready = 1'b1;
         READY_COIN:   rsp_tready = 1'($urandom_range(0, 1));
         default:      rsp_tready = ($urandom_range(0, 7) == 0);
      endcase
   end

   initial begin
      #30_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_request(input int center, input int want);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 80);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 25);
      end
      req_tvalid = 1'b1;
      req_tdata  = REQ_DATA_W'({want[FRAME_W-1:0], center[CENTER_W-1:0]});
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input int value);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = index;
      csr_wdata = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wen = 1'b0;
      case (index)
         CSR_WINDOW_MODE:  trails    = value & 1;
         CSR_CYCLE_LENGTH: cycle_cfg = value & 8'hFF;
         CSR_CLIP_FRAMES:  clip_cfg  = value & FRAME_MAX;
         default: ;
      endcase
   endtask

   task automatic set_config(input int mode, input int cyc, input int clip);
      wait_idle();
      write_csr(CSR_WINDOW_MODE, mode);
      write_csr(CSR_CYCLE_LENGTH, cyc);
      write_csr(CSR_CLIP_FRAMES, clip);
   endtask

   initial begin
      int sent;
      int center;
      int want;
      int roll;
      int first;
      int cyc;
      int clip;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register defaults: one-frame clip, so the window runs past the clip end.
      send_request(0, 0);
      send_request(0, 0);
      send_request(0, 7);
      send_request(0, FRAME_MAX);
      send_request(-1, 0);
      send_request(1, 0);

      // Largest clip with the longest trailing window.
      set_config(1, 255, FRAME_MAX);
      send_request(FRAME_MAX - 1, FRAME_MAX - 257);
      send_request(FRAME_MAX - 1, FRAME_MAX - 257);
      send_request(FRAME_MAX, 0);
      send_request(300, 44);
      send_request(301, 44);

      // Centered window: the ring rotates, then a fetch past the clip end is clamped.
      set_config(0, 0, 40);
      send_request(10, 2);
      send_request(11, 5);
      send_request(12, 5);
      send_request(39, 46);
      send_request(39, 46);
      send_request(40, 0);

      set_config(1, 0, 40);
      send_request(20, 19);
      send_request(21, 20);

      // With a zero-length clip every center is out of range.
      wait_idle();
      write_csr(CSR_CLIP_FRAMES, 0);
      write_csr(CSR_SPARE, FRAME_MAX);
      send_request(0, 0);
      send_request(5, 5);

      sent = 0;
      while (sent < RANDOM_REQS) begin
         case ($urandom_range(0, 3))
            0:       cyc = 0;
            1:       cyc = 255;
            2:       cyc = $urandom_range(1, 20);
            default: cyc = $urandom_range(0, 255);
         endcase
         case ($urandom_range(0, 4))
            0:       clip = $urandom_range(1, 4);
            1:       clip = $urandom_range(5, 60);
            2:       clip = $urandom_range(61, 100000);
            3:       clip = FRAME_MAX - $urandom_range(0, 1000);
            default: clip = $urandom_range(1, FRAME_MAX);
         endcase
         set_config($urandom_range(0, 1), cyc, clip);
         center = $urandom_range(0, clip_cfg - 1);
         repeat ($urandom_range(20, 120)) begin
            roll = $urandom_range(0, 99);
            // Mostly a center that creeps forward with requests inside its window.
            if (roll < 80) begin
               if ($urandom_range(0, 9) == 0) center -= 1;
               else center += $urandom_range(0, 2);
               if (center < 0) center = 0;
               if (center >= clip_cfg) center = clip_cfg - 1;
            end else if (roll < 88) begin
               center = $urandom_range(0, clip_cfg - 1);
            end
            first = trails ? center - 1 - cycle_cfg : center - DEPTH / 2;
            want  = first + $urandom_range(0, DEPTH - 1);
            if (want < 0) want = $urandom_range(0, DEPTH);
            if (want > FRAME_MAX) want = FRAME_MAX;
            if (roll >= 94) want = $urandom_range(0, FRAME_MAX);
            if (roll >= 88 && roll < 94) begin
               if ($urandom_range(0, 1) == 0) send_request(-1, want);
               else send_request($urandom_range(FRAME_MAX, clip_cfg), want);
            end else begin
               send_request(center, want);
            end
            sent++;
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (PIPE_CYCLES + 10) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
